[sv/hrp_pkg.sv]
// Package for the HTTP request header parser: sizes, character codes,
// result kinds, parser state and result types.
// No dependencies; every module imports it.
package hrp_pkg;

    // Largest request, in bytes, before the overflow result is given.
    localparam int MAX_REQUEST_BYTES = 4096;
    // Byte counter width: it must hold MAX_REQUEST_BYTES itself.
    localparam int CNT_W = $clog2(MAX_REQUEST_BYTES + 1);
    // Width of the reported offsets.
    localparam int POS_W = 13;

    // Result queue depth and the widths that follow from it.
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    // Tokens on the request line, and line ends that finish a request.
    localparam logic [1:0] TOKENS_PER_LINE     = 2'd3;
    localparam logic [1:0] LINE_ENDS_TO_FINISH = 2'd2;

    // Character codes.
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    typedef enum logic [2:0] {
        KIND_METHOD,
        KIND_URI,
        KIND_VERSION,
        KIND_HEADER,
        KIND_COMPLETE,
        KIND_BAD_LINE,
        KIND_OVERFLOW
    } item_kind_t;

    typedef enum logic [1:0] {
        MODE_REQ_LINE,
        MODE_HEADERS
    } parse_mode_t;

    typedef enum logic [1:0] {
        PH_NAME,
        PH_SEARCH,
        PH_VALUE
    } header_phase_t;

    // One result beat.
    typedef struct packed {
        item_kind_t        item_kind;
        logic [POS_W-1:0]  name_start;
        logic [POS_W-1:0]  name_end;
        logic [POS_W-1:0]  value_start;
        logic [POS_W-1:0]  value_end;
        logic              last_of_request;
    } result_t;

    // Results produced by one parsed byte, handed to the result queue.
    typedef struct packed {
        logic [1:0] count;
        result_t    item0;
        result_t    item1;
    } res_push_t;

    // Running parser state.
    typedef struct packed {
        logic [CNT_W-1:0] byte_position;
        parse_mode_t      parse_mode;
        header_phase_t    header_phase;
        logic [1:0]       newline_run;
        logic             carriage_pending;
        logic             newline_pending;
        logic [POS_W-1:0] field_name_start;
        logic [POS_W-1:0] field_name_end;
        logic [POS_W-1:0] field_value_start;
        logic [POS_W-1:0] field_value_trim_end;
        logic [1:0]       token_count;
        logic [POS_W-1:0] token_begin;
        logic             inside_token;
    } parse_state_t;

endpackage

[sv/hrp_in_if.sv]
// Request byte channel: valid/ready handshake with one byte per beat.
// Depends on nothing.
interface hrp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;

    modport source (output valid, output byte_value, input ready);
    modport sink   (input valid, input byte_value, output ready);
endinterface

[sv/hrp_out_if.sv]
// Result channel: valid/ready handshake with one parse result per beat.
// Depends on nothing.
interface hrp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  item_kind;
    logic [12:0] name_start;
    logic [12:0] name_end;
    logic [12:0] value_start;
    logic [12:0] value_end;
    logic        last_of_request;

    modport source (output valid, output item_kind, output name_start, output name_end,
                    output value_start, output value_end, output last_of_request,
                    input ready);
    modport sink   (input valid, input item_kind, input name_start, input name_end,
                    input value_start, input value_end, input last_of_request,
                    output ready);
endinterface

[sv/hrp_core.sv]
// Parser core: holds the running parse state and turns one byte into
// zero, one or two results. Depends on hrp_pkg.
module hrp_core
    import hrp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] byte_value,
    output res_push_t  push
);

    parse_state_t     st_reg;
    parse_state_t     st_next;
    parse_state_t     st;
    logic [CNT_W-1:0] p;
    logic [POS_W-1:0] ofs;
    logic [POS_W-1:0] ofs_next;
    logic             ws;
    res_push_t        res;

    // Space, TAB, LF, VT, FF and CR count as whitespace.
    function automatic logic is_ws(input logic [7:0] b);
        return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
    endfunction

    function automatic result_t mk(input item_kind_t kind, input logic [POS_W-1:0] a,
                                   input logic [POS_W-1:0] b, input logic [POS_W-1:0] c,
                                   input logic [POS_W-1:0] d, input logic last);
        result_t r;
        r.item_kind       = kind;
        r.name_start      = a;
        r.name_end        = b;
        r.value_start     = c;
        r.value_end       = d;
        r.last_of_request = last;
        return r;
    endfunction

    // Appends one result to the pair produced by this byte.
    function automatic res_push_t add_item(input res_push_t pin, input result_t r);
        res_push_t po;
        po = pin;
        if (pin.count == 2'd0)
        begin
            po.item0 = r;
        end
        else
        begin
            po.item1 = r;
        end
        po.count = pin.count + 2'd1;
        return po;
    endfunction

    function automatic item_kind_t token_kind(input logic [1:0] tc);
        item_kind_t k;
        case (tc)
            2'd0:    k = KIND_METHOD;
            2'd1:    k = KIND_URI;
            default: k = KIND_VERSION;
        endcase
        return k;
    endfunction

    // Next state and results for the byte in the input register.
    always_comb
    begin
        st       = st_reg;
        res      = '0;
        p        = st_reg.byte_position;
        ofs      = POS_W'(p);
        ofs_next = POS_W'(p + 1'b1);
        ws       = is_ws(byte_value);
        if (step)
        begin
            if (p >= CNT_W'(MAX_REQUEST_BYTES))
            begin
                // The request is too long: drop the byte and start over.
                res = add_item(res, mk(KIND_OVERFLOW, '0, '0, '0, '0, 1'b1));
                st  = '0;
            end
            else
            begin
                // A CR resolves here: anything but LF breaks the line-end run.
                if (st.carriage_pending)
                begin
                    st.carriage_pending = 1'b0;
                    if (byte_value != CHAR_LF)
                    begin
                        st.newline_run = '0;
                    end
                end
                st.byte_position = p + 1'b1;

                // Request line tokens are split at whitespace.
                if (st.parse_mode == MODE_REQ_LINE)
                begin
                    if (ws)
                    begin
                        if (st.inside_token)
                        begin
                            st.inside_token = 1'b0;
                            if (st.token_count < TOKENS_PER_LINE)
                            begin
                                res = add_item(res, mk(token_kind(st.token_count),
                                                       st.token_begin, ofs, '0, '0, 1'b0));
                                st.token_count = st.token_count + 2'd1;
                            end
                        end
                    end
                    else if (!st.inside_token)
                    begin
                        st.inside_token = 1'b1;
                        st.token_begin  = ofs;
                    end
                end

                if (byte_value == CHAR_LF)
                begin
                    // A line end.
                    if (st.parse_mode == MODE_HEADERS)
                    begin
                        st.newline_pending = 1'b0;
                    end
                    if (st.newline_run < LINE_ENDS_TO_FINISH)
                    begin
                        st.newline_run = st.newline_run + 2'd1;
                    end
                    if (st.parse_mode == MODE_REQ_LINE)
                    begin
                        if (st.token_count < TOKENS_PER_LINE)
                        begin
                            res = add_item(res, mk(KIND_BAD_LINE, '0, '0, '0, '0, 1'b0));
                        end
                        st.parse_mode       = MODE_HEADERS;
                        st.header_phase     = PH_NAME;
                        st.field_name_start = ofs_next;
                    end
                    else if (st.newline_run >= LINE_ENDS_TO_FINISH)
                    begin
                        if (st.header_phase == PH_VALUE)
                        begin
                            res = add_item(res, mk(KIND_HEADER, st.field_name_start,
                                                   st.field_name_end, st.field_value_start,
                                                   st.field_value_trim_end, 1'b0));
                        end
                        res = add_item(res, mk(KIND_COMPLETE, '0, '0, '0, '0, 1'b1));
                        st  = '0;
                    end
                    else if (st.header_phase == PH_VALUE)
                    begin
                        st.newline_pending = 1'b1;
                    end
                end
                else if (byte_value == CHAR_CR)
                begin
                    if (st.parse_mode == MODE_HEADERS)
                    begin
                        st.newline_pending = 1'b0;
                    end
                    st.carriage_pending = 1'b1;
                end
                else
                begin
                    st.newline_run = '0;
                    if (st.parse_mode == MODE_HEADERS)
                    begin
                        // After a line end, only whitespace continues the value.
                        if (st.newline_pending)
                        begin
                            st.newline_pending = 1'b0;
                            if (!ws)
                            begin
                                res = add_item(res, mk(KIND_HEADER, st.field_name_start,
                                                       st.field_name_end,
                                                       st.field_value_start,
                                                       st.field_value_trim_end, 1'b0));
                                st.header_phase     = PH_NAME;
                                st.field_name_start = ofs;
                            end
                        end
                        case (st.header_phase)
                            PH_NAME:
                            begin
                                if (byte_value == CHAR_COLON)
                                begin
                                    st.field_name_end = ofs;
                                    st.header_phase   = PH_SEARCH;
                                end
                            end
                            PH_SEARCH:
                            begin
                                if (!ws)
                                begin
                                    st.field_value_start    = ofs;
                                    st.field_value_trim_end = ofs_next;
                                    st.header_phase         = PH_VALUE;
                                end
                            end
                            default:
                            begin
                                if (!ws)
                                begin
                                    st.field_value_trim_end = ofs_next;
                                end
                            end
                        endcase
                    end
                end
            end
        end
        st_next = st;
        push    = res;
    end

    // Parse state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

endmodule

[sv/hrp_res_fifo.sv]
// Result queue: takes up to two results a cycle from the parser core and
// hands one per beat to the result channel. Depends on hrp_pkg, hrp_out_if.
module hrp_res_fifo
    import hrp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  res_push_t        push,
    output logic             room,
    hrp_out_if.source        res_out
);

    result_t              mem [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg;
    logic [RES_PTR_W-1:0] wr_ptr_next;
    logic [RES_PTR_W-1:0] rd_ptr_reg;
    logic [RES_PTR_W-1:0] rd_ptr_next;
    logic [RES_CNT_W-1:0] count_reg;
    logic [RES_CNT_W-1:0] count_next;
    logic                 pop;
    result_t              head;

    // There must be room for the two results one byte can cause.
    assign room = (count_reg <= RES_CNT_W'(RES_DEPTH - 2));
    assign pop  = res_out.valid && res_out.ready;
    assign head = mem[rd_ptr_reg];

    assign res_out.valid           = (count_reg != '0);
    assign res_out.item_kind       = head.item_kind;
    assign res_out.name_start      = head.name_start;
    assign res_out.name_end        = head.name_end;
    assign res_out.value_start     = head.value_start;
    assign res_out.value_end       = head.value_end;
    assign res_out.last_of_request = head.last_of_request;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + RES_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + RES_PTR_W'(pop);
        count_next  = count_reg + RES_CNT_W'(push.count) - RES_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage, written in order of production.
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.item0;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_reg + RES_PTR_W'(1)] <= push.item1;
        end
    end

endmodule

[sv/http_request_header_parser.sv]
// Top level of the HTTP request header parser: input byte register,
// parser core and result queue. Depends on hrp_pkg, hrp_in_if, hrp_out_if,
// hrp_core and hrp_res_fifo.
//
// Usage:
// Request bytes arrive one per beat on req_in. Each byte is parsed from the
// input register when the queue has room for its results; the method, URI and
// version tokens, each header, and the request complete, bad request line and
// overflow markers come out on res_out, offsets counted from the request start.
// One byte causes at most two results.
// A byte is registered on acceptance and parsed from the input register; its
// results are registered into the result queue and offered on res_out from it.
// Throughput: one byte per cycle while res_out keeps up; the output side
// moves one result per cycle, so a byte that causes two results leaves one
// waiting. The four-entry result queue holds that extra result.
// Reset clears the parser to the start of a request and empties the queue.
// When res_out stalls, the queue fills; once it cannot take two more
// results, the held byte waits and req_in.ready drops until beats drain.
module http_request_header_parser
    import hrp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    hrp_in_if.sink    req_in,
    hrp_out_if.source res_out
);

    logic       s_valid_reg;
    logic       s_valid_next;
    logic [7:0] s_byte_reg;
    logic       room;
    logic       step;
    logic       accept;
    res_push_t  push;

    // The held byte is parsed when the queue can take its results.
    assign step         = s_valid_reg && room;
    assign req_in.ready = !s_valid_reg || step;
    assign accept       = req_in.valid && req_in.ready;

    always_comb
    begin
        if (accept)
        begin
            s_valid_next = 1'b1;
        end
        else if (step)
        begin
            s_valid_next = 1'b0;
        end
        else
        begin
            s_valid_next = s_valid_reg;
        end
    end

    // Input byte register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else
        begin
            s_valid_reg <= s_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_byte_reg <= req_in.byte_value;
        end
    end

    hrp_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .byte_value (s_byte_reg),
        .push       (push)
    );

    hrp_res_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .room    (room),
        .res_out (res_out)
    );

endmodule

[sv/hrp_checker.sv]
// Port checker for the HTTP request header parser, bound to the top level.
// Depends on hrp_pkg and http_request_header_parser.
module hrp_checker
    import hrp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  item_kind,
    input logic [12:0] name_start,
    input logic [12:0] name_end,
    input logic [12:0] value_start,
    input logic [12:0] value_end,
    input logic        last_of_request
);

    logic marker;

    // Markers carry no offsets.
    assign marker = (item_kind == KIND_COMPLETE) || (item_kind == KIND_BAD_LINE) ||
                    (item_kind == KIND_OVERFLOW);

    // A stalled result beat stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat withdrawn while stalled");

    // A stalled result beat keeps its kind, name start, value end and last flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(item_kind) && $stable(name_start) &&
            $stable(value_end) && $stable(last_of_request))
        else $error("result payload changed while stalled");

    // Only complete and overflow results close a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_of_request ==
            ((item_kind == KIND_COMPLETE) || (item_kind == KIND_OVERFLOW))))
        else $error("last_of_request does not match result kind");

    // Marker results have all offsets zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && marker |-> (name_start == '0) && (name_end == '0) &&
            (value_start == '0) && (value_end == '0))
        else $error("marker result carries offsets");

    // Tokens have no value offsets, and no unused kind appears.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (item_kind != KIND_HEADER) && !marker |->
            (item_kind != 3'd7) && (value_start == '0) && (value_end == '0))
        else $error("token result carries value offsets");

endmodule

bind http_request_header_parser hrp_checker u_hrp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (res_out.valid),
    .out_ready       (res_out.ready),
    .item_kind       (res_out.item_kind),
    .name_start      (res_out.name_start),
    .name_end        (res_out.name_end),
    .value_start     (res_out.value_start),
    .value_end       (res_out.value_end),
    .last_of_request (res_out.last_of_request)
);

[tb/sv/tb_top.sv]
// Self-checking testbench for the HTTP request header parser.
// Depends on hrp_pkg, hrp_in_if, hrp_out_if and http_request_header_parser;
// it streams request bytes in and checks every result beat against its own parser.
module tb_top;
    import hrp_pkg::*;

    logic clk;
    logic rst_n;

    hrp_in_if  req_if();
    hrp_out_if res_if();

    http_request_header_parser u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req_in  (req_if),
        .res_out (res_if)
    );

    // Parser state kept by the testbench, one request at a time.
    int unsigned   req_pos;
    parse_mode_t   req_mode;
    header_phase_t hdr_phase;
    int unsigned   eol_run;
    bit            cr_open;
    bit            fold_open;
    int unsigned   hdr_name_start;
    int unsigned   hdr_name_end;
    int unsigned   hdr_value_start;
    int unsigned   hdr_value_end;
    int unsigned   tok_count;
    int unsigned   tok_start;
    bit            tok_open;

    // Parse results still to come out of the block, oldest first.
    result_t       parsed_items_due[$];
    // Request bytes not yet handed to the driver.
    logic [7:0]    request_bytes[$];

    int  error_count;
    bit  byte_taken;
    bit  result_taken;
    bit  send_active;
    int  send_gap;
    int  send_quiet;
    int  recv_stall;
    int  recv_quiet;

    // ------------------------------------------------------------------
    // Request parser used to work out the expected result beats.
    // ------------------------------------------------------------------

    function automatic bit is_blank(logic [7:0] b);
        return b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR);
    endfunction

    function automatic void add_item(item_kind_t kind, int unsigned a, int unsigned b,
                                     int unsigned c, int unsigned d, bit last);
        result_t r;
        r.item_kind       = kind;
        r.name_start      = POS_W'(a);
        r.name_end        = POS_W'(b);
        r.value_start     = POS_W'(c);
        r.value_end       = POS_W'(d);
        r.last_of_request = last;
        parsed_items_due.push_back(r);
    endfunction

    function automatic void restart_request();
        req_pos         = 0;
        req_mode        = MODE_REQ_LINE;
        hdr_phase       = PH_NAME;
        eol_run         = 0;
        cr_open         = 1'b0;
        fold_open       = 1'b0;
        hdr_name_start  = 0;
        hdr_name_end    = 0;
        hdr_value_start = 0;
        hdr_value_end   = 0;
        tok_count       = 0;
        tok_start       = 0;
        tok_open        = 1'b0;
    endfunction

    function automatic void add_header_item();
        add_item(KIND_HEADER, hdr_name_start, hdr_name_end, hdr_value_start,
                 hdr_value_end, 1'b0);
    endfunction

    // A request line token ends at offset p; only the first three are reported.
    function automatic void close_token(int unsigned p);
        if (!tok_open)
            return;
        tok_open = 1'b0;
        if (tok_count < TOKENS_PER_LINE)
        begin
            add_item(item_kind_t'(KIND_METHOD + tok_count), tok_start, p, 0, 0, 1'b0);
            tok_count++;
        end
    endfunction

    // A line end whose LF sits at offset p. Returns 1 when the request is over.
    function automatic bit line_finish(int unsigned p);
        if (eol_run < LINE_ENDS_TO_FINISH)
            eol_run++;
        if (req_mode == MODE_REQ_LINE)
        begin
            if (tok_count < TOKENS_PER_LINE)
                add_item(KIND_BAD_LINE, 0, 0, 0, 0, 1'b0);
            req_mode       = MODE_HEADERS;
            hdr_phase      = PH_NAME;
            hdr_name_start = p + 1;
            return 1'b0;
        end
        if (eol_run >= LINE_ENDS_TO_FINISH)
        begin
            if (hdr_phase == PH_VALUE)
                add_header_item();
            add_item(KIND_COMPLETE, 0, 0, 0, 0, 1'b1);
            return 1'b1;
        end
        if (hdr_phase == PH_VALUE)
            fold_open = 1'b1;
        return 1'b0;
    endfunction

    // Any byte that is neither LF nor CR.
    function automatic void plain_byte(logic [7:0] b, int unsigned p);
        eol_run = 0;
        if (req_mode == MODE_REQ_LINE)
        begin
            if (is_blank(b))
                close_token(p);
            else if (!tok_open)
            begin
                tok_open  = 1'b1;
                tok_start = p;
            end
            return;
        end
        // A value line ended; a blank byte folds, anything else starts a new header.
        if (fold_open)
        begin
            fold_open = 1'b0;
            if (!is_blank(b))
            begin
                add_header_item();
                hdr_phase      = PH_NAME;
                hdr_name_start = p;
            end
        end
        case (hdr_phase)
            PH_NAME:
            begin
                if (b == CHAR_COLON)
                begin
                    hdr_name_end = p;
                    hdr_phase    = PH_SEARCH;
                end
            end
            PH_SEARCH:
            begin
                if (!is_blank(b))
                begin
                    hdr_value_start = p;
                    hdr_value_end   = p + 1;
                    hdr_phase       = PH_VALUE;
                end
            end
            default:
            begin
                if (!is_blank(b))
                    hdr_value_end = p + 1;
            end
        endcase
    endfunction

    // Takes one accepted request byte and queues the results it causes.
    function automatic void parse_request_byte(logic [7:0] b);
        int unsigned p;
        p = req_pos;
        // A byte beyond the size limit is dropped and the request restarts.
        if (p >= MAX_REQUEST_BYTES)
        begin
            add_item(KIND_OVERFLOW, 0, 0, 0, 0, 1'b1);
            restart_request();
            return;
        end
        if (cr_open)
        begin
            cr_open = 1'b0;
            if (b == CHAR_LF)
            begin
                if (line_finish(p))
                    restart_request();
                else
                    req_pos = p + 1;
                return;
            end
            eol_run = 0;
        end
        if (b == CHAR_LF)
        begin
            if (req_mode == MODE_REQ_LINE)
                close_token(p);
            else
                fold_open = 1'b0;
            if (line_finish(p))
            begin
                restart_request();
                return;
            end
        end
        else if (b == CHAR_CR)
        begin
            if (req_mode == MODE_REQ_LINE)
                close_token(p);
            else
                fold_open = 1'b0;
            cr_open = 1'b1;
        end
        else
            plain_byte(b, p);
        req_pos = p + 1;
    endfunction

    // ------------------------------------------------------------------
    // Request byte generation.
    // ------------------------------------------------------------------

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            request_bytes.push_back(s[i]);
    endfunction

    function automatic logic [7:0] token_char();
        if ($urandom_range(0, 15) == 0)
            return 8'($urandom_range(8'h80, 8'hFF));
        return 8'($urandom_range(8'h21, 8'h7E));
    endfunction

    function automatic logic [7:0] name_char();
        logic [7:0] c;
        do
            c = token_char();
        while (c == CHAR_COLON);
        return c;
    endfunction

    function automatic logic [7:0] value_char();
        if ($urandom_range(0, 6) == 0)
            return ($urandom_range(0, 3) == 0) ? CHAR_TAB : CHAR_SPACE;
        return token_char();
    endfunction

    // Line end, either LF alone or CR LF.
    function automatic void push_eol();
        if ($urandom_range(0, 1) == 1)
            request_bytes.push_back(CHAR_CR);
        request_bytes.push_back(CHAR_LF);
    endfunction

    function automatic void push_blanks(int unsigned lo, int unsigned hi);
        int unsigned n;
        n = $urandom_range(lo, hi);
        repeat (n)
            request_bytes.push_back(($urandom_range(0, 3) == 0) ? CHAR_TAB : CHAR_SPACE);
    endfunction

    function automatic void push_value(int unsigned lo, int unsigned hi);
        int unsigned n;
        n = $urandom_range(lo, hi);
        repeat (n)
            request_bytes.push_back(value_char());
    endfunction

    // One header line; some lack the colon, some have an empty value,
    // a lone CR inside the value, or a folded continuation line.
    function automatic void push_header();
        int unsigned shape;
        int unsigned n;
        shape = $urandom_range(0, 9);
        n     = $urandom_range(1, 8);
        repeat (n)
            request_bytes.push_back(name_char());
        if (shape != 0)
            request_bytes.push_back(CHAR_COLON);
        push_blanks(0, 2);
        if (shape != 1)
        begin
            push_value(1, 12);
            push_blanks(0, 2);
        end
        if (shape == 2)
        begin
            request_bytes.push_back(CHAR_CR);
            push_value(1, 4);
        end
        if (shape == 3)
        begin
            push_eol();
            push_blanks(1, 2);
            push_value(0, 8);
        end
        push_eol();
    endfunction

    // A request: request line (sometimes short or long), headers, blank line.
    function automatic void push_request();
        int unsigned tokens;
        int unsigned hdrs;
        int unsigned n;
        if ($urandom_range(0, 5) == 0)
            tokens = $urandom_range(0, 2);
        else if ($urandom_range(0, 7) == 0)
            tokens = $urandom_range(4, 5);
        else
            tokens = 3;
        if ($urandom_range(0, 9) == 0)
            push_blanks(1, 2);
        for (int t = 0; t < tokens; t++)
        begin
            if (t > 0)
            begin
                // A lone CR is ordinary whitespace between tokens.
                if ($urandom_range(0, 11) == 0)
                    request_bytes.push_back(CHAR_CR);
                else
                    push_blanks(1, 2);
            end
            n = $urandom_range(1, 8);
            repeat (n)
                request_bytes.push_back(token_char());
        end
        if ($urandom_range(0, 7) == 0)
            push_blanks(1, 2);
        push_eol();
        hdrs = $urandom_range(0, 4);
        repeat (hdrs)
            push_header();
        push_eol();
    endfunction

    // Random bytes of any value, then two CR LF pairs.
    function automatic void push_noise();
        int unsigned n;
        n = $urandom_range(2, 30);
        repeat (n)
            request_bytes.push_back(8'($urandom_range(0, 255)));
        push_text("\r\n\r\n");
    endfunction

    // Idle cycles before the next beat on one side, with stretches of none.
    function automatic int draw_wait(inout int quiet_left);
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 40) == 0)
        begin
            quiet_left = $urandom_range(30, 120);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            error_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, driver and monitors.
    // ------------------------------------------------------------------

    initial
        clk = 1'b0;
    always #5 clk = ~clk;

    // Request side: note each accepted beat and feed the parser.
    always @(posedge clk)
    begin
        byte_taken = rst_n && req_if.valid && req_if.ready;
        if (byte_taken)
            parse_request_byte(req_if.byte_value);
    end

    // Request driver: next byte after a random gap, changed on the falling edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (send_active && byte_taken)
            begin
                send_active = 1'b0;
                send_gap    = draw_wait(send_quiet);
            end
            if (!send_active)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (request_bytes.size() != 0)
                begin
                    req_if.byte_value <= request_bytes.pop_front();
                    send_active = 1'b1;
                end
            end
            req_if.valid <= send_active;
        end
    end

    // Result side: compare each beat with the oldest result due.
    always @(posedge clk)
    begin
        result_t want;
        result_taken = rst_n && res_if.valid && res_if.ready;
        if (result_taken)
        begin
            if (parsed_items_due.size() == 0)
            begin
                $error("result beat with none due: item_kind %0d", res_if.item_kind);
                error_count++;
            end
            else
            begin
                want = parsed_items_due.pop_front();
                check_field("item_kind", want.item_kind, res_if.item_kind);
                check_field("name_start", want.name_start, res_if.name_start);
                check_field("name_end", want.name_end, res_if.name_end);
                check_field("value_start", want.value_start, res_if.value_start);
                check_field("value_end", want.value_end, res_if.value_end);
                check_field("last_of_request", want.last_of_request,
                            res_if.last_of_request);
            end
        end
    end

    // Result ready: held low for a random stall after each beat.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (result_taken)
                recv_stall = draw_wait(recv_quiet);
            if (recv_stall > 0)
            begin
                recv_stall--;
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------

    initial
    begin
        req_if.valid      = 1'b0;
        req_if.byte_value = 8'h00;
        res_if.ready      = 1'b0;
        rst_n             = 1'b0;
        error_count       = 0;
        byte_taken        = 1'b0;
        result_taken      = 1'b0;
        send_active       = 1'b0;
        send_gap          = 0;
        send_quiet        = 0;
        recv_stall        = 0;
        recv_quiet        = 0;
        restart_request();

        // Directed: extreme byte values as tokens, empty value found across a
        // line end, LF CR LF end, then a one-token request line.
        request_bytes.push_back(8'h00);
        push_text(" ");
        request_bytes.push_back(8'hFF);
        push_text("\tv x\r\n");
        push_text("k:\r\n v\n\r\n");
        push_text("A\n\n");

        // Random requests, with some noise mixed in.
        while (request_bytes.size() < 1400)
        begin
            if ($urandom_range(0, 6) == 0)
                push_noise();
            else
                push_request();
        end

        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (request_bytes.size() != 0 || send_active || parsed_items_due.size() != 0)
            @(posedge clk);
        repeat (12)
            @(posedge clk);

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Guard against a hung run.
    initial
    begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
